// File: hw/rtl/csd_pkg.sv
package csd_pkg;

    localparam int CSD_MAX_COEFFS = 64;
    localparam int CSD_COEF_WIDTH = 32;
    localparam int CSD_SUM_W      = 48;

    localparam logic [1:0] CSD_MODE_FULL = 2'd0;
    localparam logic [1:0] CSD_MODE_EVEN = 2'd1;
    localparam logic [1:0] CSD_MODE_ODD  = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ACC,
        ST_READ,
        ST_MUL,
        ST_CALC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_en;
        logic acc_en;
        logic rd_en;
        logic mul_en;
        logic calc_en;
        logic next_k;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic last_in;
        logic last_k;
    } t_stat;

endpackage

// File: hw/rtl/csd_ifs.sv
interface csd_coef_if
    import csd_pkg::*;
#(
    parameter int COEF_WIDTH = CSD_COEF_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coefficient;
    logic                         last;

    modport source (output valid, coefficient, last, input ready);
    modport sink   (input valid, coefficient, last, output ready);
endinterface

interface csd_deriv_if
    import csd_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [CSD_SUM_W-1:0] derivative;
    logic                        last_out;
    logic [1:0]                  result_basis;

    modport source (output valid, derivative, last_out, result_basis, input ready);
    modport sink   (input valid, derivative, last_out, result_basis, output ready);
endinterface

interface csd_cfg_if ();
    logic       valid;
    logic       ready;
    logic [1:0] basis_mode;

    modport source (output valid, basis_mode, input ready);
    modport sink   (input valid, basis_mode, output ready);
endinterface

// File: hw/rtl/csd_ram.sv
module csd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/csd_ctrl.sv
module csd_ctrl
    import csd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_state = i_stat.last_in ? ST_READ : ST_LOAD;
            end
            ST_READ: n_state = ST_MUL;
            ST_MUL:  n_state = ST_CALC;
            ST_CALC: n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = i_stat.last_k ? ST_LOAD : ST_READ;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.load_en = i_in_valid;
            end
            ST_ACC:  o_cmd.acc_en  = 1'b1;
            ST_READ: o_cmd.rd_en   = 1'b1;
            ST_MUL:  o_cmd.mul_en  = 1'b1;
            ST_CALC: o_cmd.calc_en = 1'b1;
            ST_OUT: begin
                o_out_valid  = 1'b1;
                o_cmd.next_k = i_out_ready && !i_stat.last_k;
                o_cmd.clear  = i_out_ready && i_stat.last_k;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: hw/rtl/csd_datapath.sv
module csd_datapath
    import csd_pkg::*;
#(
    parameter int MAX_COEFFS = CSD_MAX_COEFFS,
    parameter int COEF_WIDTH = CSD_COEF_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    input  logic signed [COEF_WIDTH-1:0] i_coefficient,
    input  logic                        i_last,
    input  logic [1:0]                  i_basis_mode,
    output logic signed [CSD_SUM_W-1:0] o_derivative,
    output logic                        o_last_out,
    output logic [1:0]                  o_result_basis
);

    localparam int IDX_W  = $clog2(MAX_COEFFS);
    localparam int CNT_W  = $clog2(MAX_COEFFS + 1);
    localparam int PROD_W = IDX_W + 1 + COEF_WIDTH;

    logic [CNT_W-1:0]            r_count;
    logic [IDX_W-1:0]            r_k;
    logic                        r_last;
    logic                        r_take;
    logic                        r_par;
    logic signed [CSD_SUM_W-1:0] r_prod;
    logic signed [CSD_SUM_W-1:0] r_coef;
    logic signed [CSD_SUM_W-1:0] r_sum_even;
    logic signed [CSD_SUM_W-1:0] r_sum_odd;
    logic signed [CSD_SUM_W-1:0] r_sum_a;
    logic signed [CSD_SUM_W-1:0] r_deriv;
    logic                        r_last_out;
    logic [1:0]                  r_basis;

    logic signed [CSD_SUM_W-1:0] n_sum_even;
    logic signed [CSD_SUM_W-1:0] n_sum_odd;
    logic signed [CSD_SUM_W-1:0] n_sum_a;

    logic                         full;
    logic [COEF_WIDTH-1:0]        ram_rdata;
    logic [IDX_W-1:0]             mul_idx;
    logic signed [COEF_WIDTH-1:0] mul_val;
    logic signed [PROD_W-1:0]     prod;
    logic signed [CSD_SUM_W-1:0]  calc_res;
    logic [1:0]                   calc_code;
    logic                         last_k;

    assign full   = (r_count == CNT_W'(MAX_COEFFS));
    assign last_k = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);

    assign o_stat.last_in = r_last;
    assign o_stat.last_k  = last_k;

    csd_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (MAX_COEFFS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load_en && !full),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (i_coefficient),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_k),
        .o_rd_data (ram_rdata)
    );

    // one multiplier: index * coefficient, on load and on emit
    assign mul_idx = i_cmd.mul_en ? r_k : r_count[IDX_W-1:0];
    assign mul_val = i_cmd.mul_en ? $signed(ram_rdata) : i_coefficient;
    assign prod    = $signed({1'b0, mul_idx}) * mul_val;

    // sums hold the part of the line at or above index k
    always_comb begin
        logic signed [CSD_SUM_W-1:0] sum_eo;
        logic signed [CSD_SUM_W-1:0] odd_sum;
        logic signed [CSD_SUM_W-1:0] sel;
        sum_eo  = r_sum_even + r_sum_odd;
        odd_sum = (sum_eo <<< 1) + r_sum_a;
        sel     = r_k[0] ? r_sum_even : r_sum_odd;
        case (i_basis_mode)
            CSD_MODE_EVEN: begin
                calc_res  = (sum_eo - r_prod) <<< 2;
                calc_code = CSD_MODE_EVEN;
            end
            CSD_MODE_ODD: begin
                calc_res  = (r_k == '0) ? odd_sum : (odd_sum <<< 1);
                calc_code = CSD_MODE_ODD;
            end
            default: begin
                calc_res  = (r_k == '0) ? sel : (sel <<< 1);
                calc_code = CSD_MODE_FULL;
            end
        endcase
    end

    always_comb begin
        n_sum_even = r_sum_even;
        n_sum_odd  = r_sum_odd;
        n_sum_a    = r_sum_a;
        if (i_cmd.clear) begin
            n_sum_even = '0;
            n_sum_odd  = '0;
            n_sum_a    = '0;
        end else if (i_cmd.acc_en && r_take) begin
            if (r_par) begin
                n_sum_odd = r_sum_odd + r_prod;
            end else begin
                n_sum_even = r_sum_even + r_prod;
            end
            n_sum_a = r_sum_a + r_coef;
        end else if (i_cmd.calc_en) begin
            if (r_k[0]) begin
                n_sum_odd = r_sum_odd - r_prod;
            end else begin
                n_sum_even = r_sum_even - r_prod;
            end
            n_sum_a = r_sum_a - r_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_k        <= '0;
            r_last     <= 1'b0;
            r_take     <= 1'b0;
            r_sum_even <= '0;
            r_sum_odd  <= '0;
            r_sum_a    <= '0;
        end else begin
            r_sum_even <= n_sum_even;
            r_sum_odd  <= n_sum_odd;
            r_sum_a    <= n_sum_a;
            if (i_cmd.load_en) begin
                r_last <= i_last;
                r_take <= !full;
                if (!full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_k     <= '0;
            end else if (i_cmd.next_k) begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_prod <= CSD_SUM_W'(prod);
            r_coef <= CSD_SUM_W'(i_coefficient);
            r_par  <= r_count[0];
        end
        if (i_cmd.mul_en) begin
            r_prod <= CSD_SUM_W'(prod);
            r_coef <= CSD_SUM_W'($signed(ram_rdata));
        end
        if (i_cmd.calc_en) begin
            r_deriv    <= calc_res;
            r_last_out <= last_k;
            r_basis    <= calc_code;
        end
    end

    assign o_derivative   = r_deriv;
    assign o_last_out     = r_last_out;
    assign o_result_basis = r_basis;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_COEFFS))
        else $error("load count beyond store depth");

    a_read_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (CNT_W'(r_k) < r_count))
        else $error("read beyond loaded line");

    a_sums_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> (r_sum_even == '0 && r_sum_odd == '0 && r_sum_a == '0))
        else $error("suffix sums not drained at end of line");

endmodule

// File: hw/rtl/chebyshev_series_derivative_unit.sv
// channel  dir  beat                                   accepted when
// i_coef   in   coefficient (s32 Q7.24), last           valid && ready
// o_deriv  out  derivative (s48 Q23.24), last_out,      valid && ready
//               result_basis
// i_cfg    in   basis_mode                             valid && ready (ready tied high)
//
// Load: store write and index multiply (ST_LOAD), then accumulate (ST_ACC), per coefficient.
// Emit: per derivative coefficient, ST_READ, ST_MUL, ST_CALC, then ST_OUT until accepted;
// each coefficient is read back from the store and multiplied again.
// Input is not taken while a line is being emitted.
// Reset (synchronous, active low) clears load count, sums and basis_mode.
module chebyshev_series_derivative_unit
    import csd_pkg::*;
#(
    parameter int MAX_COEFFS = CSD_MAX_COEFFS,
    parameter int COEF_WIDTH = CSD_COEF_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    csd_coef_if.sink            i_coef,
    csd_deriv_if.source         o_deriv,
    csd_cfg_if.sink             i_cfg
);

    logic [1:0] r_basis_mode;
    t_cmd       cmd;
    t_stat      stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis_mode <= CSD_MODE_FULL;
        end else if (i_cfg.valid) begin
            r_basis_mode <= i_cfg.basis_mode;
        end
    end

    csd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_coef.valid),
        .o_in_ready  (i_coef.ready),
        .o_out_valid (o_deriv.valid),
        .i_out_ready (o_deriv.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    csd_datapath #(
        .MAX_COEFFS (MAX_COEFFS),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_coefficient  (i_coef.coefficient),
        .i_last         (i_coef.last),
        .i_basis_mode   (r_basis_mode),
        .o_derivative   (o_deriv.derivative),
        .o_last_out     (o_deriv.last_out),
        .o_result_basis (o_deriv.result_basis)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import csd_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int WATCHDOG  = 4000;
    localparam int HOLD_AT   = 100;
    localparam int HOLD_LEN  = 400;
    localparam int SETTLE    = 12;
    localparam int DRAIN     = 40;

    typedef struct packed {
        logic [CSD_SUM_W-1:0] deriv;
        logic                 last_out;
        logic [1:0]           basis;
    } t_deriv_beat;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [CSD_COEF_WIDTH-1:0]   coef;
        logic                        last;
        logic                        known;
        logic [CSD_SUM_W-1:0]        known_d;
    } t_coef_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    csd_coef_if  coef_if ();
    csd_deriv_if deriv_if ();
    csd_cfg_if   cfg_if ();

    chebyshev_series_derivative_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef_if),
        .o_deriv (deriv_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic signed [CSD_COEF_WIDTH-1:0] line_coefs [CSD_MAX_COEFFS];
    int          line_len;
    logic [1:0]  mode_now;
    t_deriv_beat deriv_due [$];
    int          fail_count;
    int          beats_seen;
    int          tx_idle_pct;
    int          rx_idle_pct;

    // mode column changes only at line boundaries; known_d is res[0] of the line
    t_coef_row coef_rows [22] = '{
        '{CSD_MODE_FULL, 32'h7FFF_FFFF, 1'b1, 1'b1, 48'h0},
        '{CSD_MODE_FULL, 32'h8000_0000, 1'b1, 1'b1, 48'h0},
        '{CSD_MODE_FULL, 32'h0000_0005, 1'b0, 1'b0, 48'h0},
        '{CSD_MODE_FULL, 32'h7FFF_FFFF, 1'b1, 1'b1, 48'h0000_7FFF_FFFF},
        '{CSD_MODE_FULL, 32'h0000_0000, 1'b0, 1'b0, 48'h0},
        '{CSD_MODE_FULL, 32'h8000_0000, 1'b1, 1'b1, 48'hFFFF_8000_0000},
        '{CSD_MODE_FULL, 32'h0100_0000, 1'b0, 1'b0, 48'h0},
        '{CSD_MODE_FULL, 32'hFF00_0000, 1'b0, 1'b0, 48'h0},
        '{CSD_MODE_FULL, 32'h7FFF_FFFF, 1'b0, 1'b0, 48'h0},
        '{CSD_MODE_FULL, 32'h8000_0000, 1'b1, 1'b0, 48'h0},
        '{CSD_MODE_EVEN, 32'h7FFF_FFFF, 1'b1, 1'b1, 48'h0},
        '{CSD_MODE_EVEN, 32'hFFFF_FFFF, 1'b0, 1'b0, 48'h0},
        '{CSD_MODE_EVEN, 32'h1234_5678, 1'b0, 1'b0, 48'h0},
        '{CSD_MODE_EVEN, 32'h8000_0000, 1'b1, 1'b0, 48'h0},
        '{CSD_MODE_ODD,  32'h7FFF_FFFF, 1'b1, 1'b1, 48'h0000_7FFF_FFFF},
        '{CSD_MODE_ODD,  32'h8000_0000, 1'b1, 1'b1, 48'hFFFF_8000_0000},
        '{CSD_MODE_ODD,  32'h0000_0001, 1'b0, 1'b0, 48'h0},
        '{CSD_MODE_ODD,  32'h7FFF_FFFF, 1'b0, 1'b0, 48'h0},
        '{CSD_MODE_ODD,  32'h8000_0000, 1'b1, 1'b0, 48'h0},
        '{MODE_UNUSED,   32'h7FFF_FFFF, 1'b1, 1'b1, 48'h0},
        '{MODE_UNUSED,   32'h0000_0003, 1'b0, 1'b0, 48'h0},
        '{MODE_UNUSED,   32'h8000_0000, 1'b1, 1'b0, 48'h0}
    };

    // backward suffix-sum pass over the held line
    function automatic void derive_line(input logic known,
                                        input logic [CSD_SUM_W-1:0] known_d);
        logic [CSD_SUM_W-1:0] sum_even;
        logic [CSD_SUM_W-1:0] sum_odd;
        logic [CSD_SUM_W-1:0] r;
        logic [CSD_SUM_W-1:0] a;
        logic [CSD_SUM_W-1:0] kk;
        logic [CSD_SUM_W-1:0] res [CSD_MAX_COEFFS];
        logic [1:0]           basis;
        t_deriv_beat          beat;
        basis = (mode_now == CSD_MODE_EVEN || mode_now == CSD_MODE_ODD) ?
                mode_now : CSD_MODE_FULL;
        sum_even = '0;
        sum_odd  = '0;
        for (int k = line_len - 1; k >= 0; k--) begin
            a  = {{(CSD_SUM_W-CSD_COEF_WIDTH){line_coefs[k][CSD_COEF_WIDTH-1]}},
                  line_coefs[k]};
            kk = CSD_SUM_W'(k);
            case (basis)
                CSD_MODE_EVEN: begin
                    r = sum_even << 2;
                    sum_even = sum_even + kk * a;
                end
                CSD_MODE_ODD: begin
                    sum_even = sum_even + (2 * kk + 1) * a;
                    r = (k != 0) ? (sum_even << 1) : sum_even;
                end
                default: begin
                    r = k[0] ? sum_even : sum_odd;
                    if (k != 0)
                        r = r << 1;
                    if (k[0])
                        sum_odd = sum_odd + kk * a;
                    else
                        sum_even = sum_even + kk * a;
                end
            endcase
            res[k] = r;
        end
        if (known)
            res[0] = known_d;
        for (int k = 0; k < line_len; k++) begin
            beat.deriv    = res[k];
            beat.last_out = (k == line_len - 1);
            beat.basis    = basis;
            deriv_due.push_back(beat);
        end
        line_len = 0;
    endfunction

    function automatic logic [CSD_COEF_WIDTH-1:0] rand_coef();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: return {{8{raw[24]}}, raw[23:0]};
            default: return raw;
        endcase
    endfunction

    task automatic offer_coef(input logic [CSD_COEF_WIDTH-1:0] c, input logic l,
                              input logic known, input logic [CSD_SUM_W-1:0] known_d);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            coef_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        coef_if.valid       <= 1'b1;
        coef_if.coefficient <= c;
        coef_if.last        <= l;
        @(posedge i_clk);
        while (!coef_if.ready)
            @(posedge i_clk);
        if (line_len < CSD_MAX_COEFFS) begin
            line_coefs[line_len] = c;
            line_len++;
        end
        if (l)
            derive_line(known, known_d);
    endtask

    task automatic send_line(input int len);
        for (int i = 0; i < len; i++)
            offer_coef(rand_coef(), i == len - 1, 1'b0, '0);
    endtask

    task automatic settle();
        coef_if.valid <= 1'b0;
        while (deriv_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_basis(input logic [1:0] mode);
        cfg_if.valid      <= 1'b1;
        cfg_if.basis_mode <= mode;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        mode_now = mode;
    endtask

    initial begin : deriv_sink
        t_deriv_beat want;
        int          hold_left;
        logic        hold_done;
        deriv_if.ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && deriv_if.valid && deriv_if.ready) begin
                beats_seen++;
                if (deriv_due.size() == 0) begin
                    $error("derivative: unexpected beat %h", deriv_if.derivative);
                    fail_count++;
                end else begin
                    want = deriv_due.pop_front();
                    if (deriv_if.derivative !== want.deriv) begin
                        $error("derivative: expected %h, actual %h",
                               want.deriv, deriv_if.derivative);
                        fail_count++;
                    end
                    if (deriv_if.last_out !== want.last_out) begin
                        $error("last_out: expected %b, actual %b",
                               want.last_out, deriv_if.last_out);
                        fail_count++;
                    end
                    if (deriv_if.result_basis !== want.basis) begin
                        $error("result_basis: expected %0d, actual %0d",
                               want.basis, deriv_if.result_basis);
                        fail_count++;
                    end
                end
            end
            // long back-pressure while the next line waits, so the input stalls
            if (!hold_done && beats_seen >= HOLD_AT && deriv_if.valid && coef_if.valid) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                deriv_if.ready <= 1'b0;
            end else begin
                deriv_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((coef_if.valid && coef_if.ready) || (deriv_if.valid && deriv_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int len;
        int sent;
        coef_if.valid       = 1'b0;
        coef_if.coefficient = '0;
        coef_if.last        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.basis_mode   = CSD_MODE_FULL;
        i_rst_n             = 1'b0;
        line_len    = 0;
        mode_now    = CSD_MODE_FULL;
        fail_count  = 0;
        beats_seen  = 0;
        tx_idle_pct = 15;
        rx_idle_pct = 76;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (coef_rows[i]) begin
            if (coef_rows[i].mode != mode_now) begin
                settle();
                set_basis(coef_rows[i].mode);
            end
            offer_coef(coef_rows[i].coef, coef_rows[i].last,
                       coef_rows[i].known, coef_rows[i].known_d);
        end

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin tx_idle_pct = 15; rx_idle_pct = 76; end
                1: begin tx_idle_pct = 76; rx_idle_pct = 15; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int m = 0; m < 4; m++) begin
                settle();
                set_basis(2'((m + p) % 4));
                sent = 0;
                if (m == p) begin
                    // overflows the store; the extra beats are dropped
                    len = $urandom_range(CSD_MAX_COEFFS + 1, CSD_MAX_COEFFS + 6);
                    send_line(len);
                    sent = len;
                end
                while (sent < 6) begin
                    if ($urandom_range(0, 99) < 85)
                        len = $urandom_range(1, 8);
                    else
                        len = $urandom_range(9, 40);
                    send_line(len);
                    sent += len;
                end
            end
        end

        coef_if.valid <= 1'b0;
        while (deriv_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/csd_pkg.sv
hw/rtl/csd_ifs.sv
hw/rtl/csd_ram.sv
hw/rtl/csd_ctrl.sv
hw/rtl/csd_datapath.sv
hw/rtl/chebyshev_series_derivative_unit.sv
tb/sv/tb.sv
